[sv/btmc_pkg.sv]
`timescale 1ns / 1ps

package btmc_pkg;

   localparam int ROW_BITS     = 64;
   localparam int PAT_BITS     = 20;
   localparam int WIDTH_BITS   = 7;
   localparam int COUNT_BITS   = 13;
   localparam int COUNT_MAX    = 4096;
   localparam int CSR_DATA_BITS = 20;

   localparam int IMG_W_DEFAULT    = 64;
   localparam int PAT_W_DEFAULT    = 20;
   localparam int PAT_H_DEFAULT    = 3;
   localparam int MAX_ROWS_DEFAULT = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WIDTH_BITS-1:0] ACTIVE_WIDTH_RESET = WIDTH_BITS'(64);

   typedef enum logic [1:0] {
      CSR_PATTERN_TOP,
      CSR_PATTERN_MID,
      CSR_PATTERN_BOTTOM,
      CSR_ACTIVE_WIDTH
   } csr_index_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] row_pixels;
      logic                last_row;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] unmarked_count;
      logic [COUNT_BITS-1:0] match_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [PAT_BITS-1:0]   pattern_row_top;
      logic [PAT_BITS-1:0]   pattern_row_mid;
      logic [PAT_BITS-1:0]   pattern_row_bottom;
      logic [WIDTH_BITS-1:0] active_width;
   } cfg_type;

   // One masked row waiting between the front and the back.
   typedef struct packed {
      logic [ROW_BITS-1:0] row;
      logic                last;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_out_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [3:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + (COUNT_BITS + 1)'(b);
      if (s > (COUNT_BITS + 1)'(COUNT_MAX)) begin
         return COUNT_BITS'(COUNT_MAX);
      end
      return s[COUNT_BITS-1:0];
   endfunction

endpackage

[sv/btmc_front.sv]
`timescale 1ns / 1ps

module btmc_front
   import btmc_pkg::*;
#(
   parameter int IMG_W = IMG_W_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic [WIDTH_BITS-1:0] active_width,
   input  logic                  q_pop,
   output queue_out_type         q_out
);

   localparam logic [WIDTH_BITS-1:0] IMG_W_V = WIDTH_BITS'(IMG_W);

   queue_item_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]     count_ff, count_in;
   logic [WIDTH_BITS-1:0]    eff_width;
   logic [ROW_BITS-1:0]      col_mask;
   queue_item_type           new_item;
   logic                     push;

   // Columns at or past the active width never enter the queue.
   always_comb begin
      eff_width = (active_width > IMG_W_V) ? IMG_W_V : active_width;
      for (int i = 0; i < ROW_BITS; i++) begin
         col_mask[i] = (WIDTH_BITS'(i) < eff_width);
      end
      new_item.row  = req_payload.row_pixels & col_mask;
      new_item.last = req_payload.last_row;
   end

   assign req_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign q_out = {(count_ff != '0), mem_ff[rd_ptr_ff]};

endmodule

[sv/btmc_engine.sv]
`timescale 1ns / 1ps

module btmc_engine
   import btmc_pkg::*;
#(
   parameter int IMG_W    = IMG_W_DEFAULT,
   parameter int PAT_W    = PAT_W_DEFAULT,
   parameter int PAT_H    = PAT_H_DEFAULT,
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  queue_out_type   q_out,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int POS_W  = $clog2(IMG_W);
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int DRN_W  = $clog2(PAT_H + 1);
   localparam int RET_W  = ((IMG_W + 7) / 8) * 8;

   localparam logic [WIDTH_BITS-1:0] IMG_W_V    = WIDTH_BITS'(IMG_W);
   localparam logic [WIDTH_BITS-1:0] PAT_W_V    = WIDTH_BITS'(PAT_W);
   localparam logic [ROWS_W+1:0]     PAT_H_V    = (ROWS_W + 2)'(PAT_H);
   localparam logic [ROWS_W-1:0]     MAX_ROWS_V = ROWS_W'(MAX_ROWS);
   localparam logic [DRN_W-1:0]      DRAIN_END  = DRN_W'(PAT_H);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [IMG_W-1:0]      win_pix_ff [PAT_H];
   logic [IMG_W-1:0]      win_pix_in [PAT_H];
   logic [IMG_W-1:0]      win_mark_ff [PAT_H];
   logic [IMG_W-1:0]      win_mark_in [PAT_H];
   logic [IMG_W-1:0]      need_ff [PAT_H];
   logic [IMG_W-1:0]      need_in [PAT_H];
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ROWS_W-1:0]     rows_ff, rows_in;
   logic [COUNT_BITS-1:0] unm_ff, unm_in;
   logic [COUNT_BITS-1:0] mat_ff, mat_in;
   logic [RET_W-1:0]      ret_ff, ret_in;
   logic [DRN_W-1:0]      drain_ff, drain_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [WIDTH_BITS-1:0] eff_width;
   logic [WIDTH_BITS-1:0] last_pos;
   logic                  scan_ok;
   logic                  hit;
   logic [PAT_BITS-1:0]   pat_mask;
   logic [PAT_BITS-1:0]   pat_row [PAT_H];

   always_comb begin
      eff_width = (cfg.active_width > IMG_W_V) ? IMG_W_V : cfg.active_width;
      scan_ok   = (eff_width >= PAT_W_V);
      last_pos  = eff_width - PAT_W_V;
      for (int i = 0; i < PAT_BITS; i++) begin
         pat_mask[i] = (i < PAT_W);
      end
      for (int j = 0; j < PAT_H; j++) begin
         case (j)
            0:       pat_row[j] = cfg.pattern_row_top & pat_mask;
            1:       pat_row[j] = cfg.pattern_row_mid & pat_mask;
            default: pat_row[j] = cfg.pattern_row_bottom & pat_mask;
         endcase
      end
      // A position hits when every required pixel is set and still unmarked.
      hit = 1'b1;
      for (int j = 0; j < PAT_H; j++) begin
         if ((need_ff[j] & ~(win_pix_ff[j] & ~win_mark_ff[j])) != '0) begin
            hit = 1'b0;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      win_pix_in   = win_pix_ff;
      win_mark_in  = win_mark_ff;
      need_in      = need_ff;
      pos_in       = pos_ff;
      rows_in      = rows_ff;
      mat_in       = mat_ff;
      drain_in     = drain_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      q_pop        = 1'b0;

      // Retire counter: one byte of the retired row per cycle.
      ret_in = ret_ff >> 8;
      unm_in = sat_add(unm_ff, popcount8(ret_ff[7:0]));

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid && (ret_ff == '0)) begin
               q_pop   = 1'b1;
               last_in = q_out.item.last;
               if ({2'b00, rows_ff} >= PAT_H_V) begin
                  ret_in = RET_W'(win_pix_ff[0] & ~win_mark_ff[0]);
               end
               for (int j = 0; j < PAT_H - 1; j++) begin
                  win_pix_in[j]  = win_pix_ff[j+1];
                  win_mark_in[j] = win_mark_ff[j+1];
               end
               win_pix_in[PAT_H-1]  = q_out.item.row[IMG_W-1:0];
               win_mark_in[PAT_H-1] = '0;
               if (rows_ff < MAX_ROWS_V) begin
                  rows_in = rows_ff + 1'b1;
               end
               for (int j = 0; j < PAT_H; j++) begin
                  need_in[j] = IMG_W'(pat_row[j]);
               end
               pos_in   = '0;
               drain_in = '0;
               if (({2'b00, rows_in} >= PAT_H_V) && scan_ok) begin
                  state_in = ST_SCAN;
               end else if (q_out.item.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               for (int j = 0; j < PAT_H; j++) begin
                  win_mark_in[j] = win_mark_ff[j] | need_ff[j];
               end
               mat_in = sat_add(mat_ff, 4'd1);
            end
            for (int j = 0; j < PAT_H; j++) begin
               need_in[j] = need_ff[j] << 1;
            end
            pos_in = pos_ff + 1'b1;
            if (WIDTH_BITS'(pos_ff) == last_pos) begin
               state_in = last_ff ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            // Feed each held row through the retire counter, oldest first.
            if (ret_ff == '0) begin
               if (drain_ff == DRAIN_END) begin
                  state_in = ST_DONE;
               end else begin
                  ret_in = RET_W'(win_pix_ff[0] & ~win_mark_ff[0]);
                  for (int j = 0; j < PAT_H - 1; j++) begin
                     win_pix_in[j]  = win_pix_ff[j+1];
                     win_mark_in[j] = win_mark_ff[j+1];
                  end
                  win_pix_in[PAT_H-1]  = '0;
                  win_mark_in[PAT_H-1] = '0;
                  drain_in = drain_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.unmarked_count = unm_ff;
               rsp_in.match_count    = mat_ff;
               rsp_valid_in          = 1'b1;
               for (int j = 0; j < PAT_H; j++) begin
                  win_pix_in[j]  = '0;
                  win_mark_in[j] = '0;
               end
               rows_in  = '0;
               unm_in   = '0;
               mat_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= '0;
         unm_ff       <= '0;
         mat_ff       <= '0;
         ret_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < PAT_H; j++) begin
            win_pix_ff[j]  <= '0;
            win_mark_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         unm_ff       <= unm_in;
         mat_ff       <= mat_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         win_pix_ff   <= win_pix_in;
         win_mark_ff  <= win_mark_in;
      end
      need_ff  <= need_in;
      pos_ff   <= pos_in;
      drain_ff <= drain_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[sv/binary_template_match_count_unit.sv]
`timescale 1ns / 1ps

// Binary template match counter.
// The req channel carries one image row per transaction (bit i is column i) with
// last_row set on the final row. The rsp channel carries one transaction per image:
// the count of set pixels never covered by a match and the count of matches, both
// saturating at 4096. The csr port writes the three pattern rows and the active
// width; write it only while the block is idle.
// A row enters a two-entry queue in the cycle it is accepted. The scan engine then
// takes the row and tests one window position per cycle, min(active_width, IMG_W)
// - PAT_W + 1 positions (45 at the defaults). When no positions are scanned, the
// byte-serial counter of the retired row sets the pace. After the last row the
// PAT_H held rows are counted, oldest first, and then the result is registered.
// Reset returns the registers to their defaults and clears the window, marks and
// totals at once; no clearing pass is needed.
// A stalled rsp receiver holds the result in the output register while the next
// image is processed; the engine waits only when a second result is ready, and
// req_ready drops once the queue is full.

module binary_template_match_count_unit
   import btmc_pkg::*;
#(
   parameter int IMG_W    = IMG_W_DEFAULT,
   parameter int PAT_W    = PAT_W_DEFAULT,
   parameter int PAT_H    = PAT_H_DEFAULT,
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_payload_type          rsp_payload,
   input  logic                     csr_wr_en,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   queue_out_type q_out;
   logic          q_pop;

   // Configuration registers, each keeping only its own width of the write data.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_TOP:    cfg_in.pattern_row_top    = csr_wdata[PAT_BITS-1:0];
            CSR_PATTERN_MID:    cfg_in.pattern_row_mid    = csr_wdata[PAT_BITS-1:0];
            CSR_PATTERN_BOTTOM: cfg_in.pattern_row_bottom = csr_wdata[PAT_BITS-1:0];
            CSR_ACTIVE_WIDTH:   cfg_in.active_width       = csr_wdata[WIDTH_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_row_top    <= '0;
         cfg_ff.pattern_row_mid    <= '0;
         cfg_ff.pattern_row_bottom <= '0;
         cfg_ff.active_width       <= ACTIVE_WIDTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front masks each row to the active width and queues it.
   btmc_front #(
      .IMG_W(IMG_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .active_width(cfg_ff.active_width),
      .q_pop       (q_pop),
      .q_out       (q_out)
   );

   // The engine slides the window, scans positions in order and keeps the totals.
   btmc_engine #(
      .IMG_W   (IMG_W),
      .PAT_W   (PAT_W),
      .PAT_H   (PAT_H),
      .MAX_ROWS(MAX_ROWS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

`ifndef ASSERT_OFF
   // The engine never takes a row from an empty queue.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_out.valid)
      else $error("row taken from an empty queue");

   // Back pressure on req means the queue holds rows for the engine.
   a_full_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_out.valid)
      else $error("req stalled with an empty queue");

   // Saturated totals never exceed the ceiling.
   a_counts_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.unmarked_count <= COUNT_BITS'(COUNT_MAX)) &&
                    (rsp_payload.match_count <= COUNT_BITS'(COUNT_MAX)))
      else $error("result count above the saturation limit");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for binary_template_match_count_unit.
//
// Rows of a binary image go in on the req channel, one per transaction. When
// the row flagged last_row has been taken, the block returns one rsp
// transaction with the count of set pixels that no match covered and the
// count of matches found. The bench keeps its own copy of the row window,
// the mark bits and both totals, so it can predict every count. It queues
// the prediction when the last row of an image is accepted. A checking
// process then compares each returned transaction with the oldest
// prediction, one field at a time.
//
// The csr registers are only rewritten when the block is idle: every
// expected count has come back and a settling pause has gone by.

module tb_top;
   import btmc_pkg::*;

   // Pause after the last count comes back, so that the block can go quiet.
   localparam int SETTLE_CYCLES = 100;
   // Upper bound on the run; a run that reaches it is ended as a failure.
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_ROWS    = 45;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     csr_wr_en   = 1'b0;
   csr_index_type            csr_index   = CSR_PATTERN_TOP;
   logic [CSR_DATA_BITS-1:0] csr_wdata   = '0;

   // Percent chance, per cycle, that the sender holds back or the receiver stalls.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;

   // Predicted counts, oldest first, for images whose last row has gone in.
   rsp_payload_type expected_counts_q[$];

   // Shadow copy of the registers.
   logic [PAT_BITS-1:0]   pattern_mask [PAT_H_DEFAULT];
   logic [WIDTH_BITS-1:0] active_width_cfg;

   // Shadow copy of the image state. Index 0 of the window is the oldest row.
   logic [ROW_BITS-1:0] window_rows  [PAT_H_DEFAULT];
   logic [ROW_BITS-1:0] window_marks [PAT_H_DEFAULT];
   int                  rows_held;
   int                  unmarked_total;
   int                  match_total;

   binary_template_match_count_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A hung block must not keep the run alive forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate the current phase asks for.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic int saturate_count(input int value);
      return (value > COUNT_MAX) ? COUNT_MAX : value;
   endfunction

   // Widths above the row size act as the full row.
   function automatic int effective_width();
      return (active_width_cfg > ROW_BITS) ? ROW_BITS : int'(active_width_cfg);
   endfunction

   task automatic clear_image_state();
      for (int j = 0; j < PAT_H_DEFAULT; j++) begin
         window_rows[j]  = '0;
         window_marks[j] = '0;
      end
      rows_held      = 0;
      unmarked_total = 0;
      match_total    = 0;
   endtask

   task automatic reset_shadow();
      for (int j = 0; j < PAT_H_DEFAULT; j++) begin
         pattern_mask[j] = '0;
      end
      active_width_cfg = ACTIVE_WIDTH_RESET;
      clear_image_state();
   endtask

   // Test every window position of the oldest held row, left to right. A hit
   // marks the pixels under the pattern, and those marks can block the
   // positions that are tested after it.
   task automatic scan_oldest_row();
      int                  width;
      bit                  hit;
      logic [ROW_BITS-1:0] need;
      width = effective_width();
      for (int i = 0; i + PAT_BITS <= width; i++) begin
         hit = 1'b1;
         for (int j = 0; j < PAT_H_DEFAULT; j++) begin
            need = ROW_BITS'(pattern_mask[j]) << i;
            if ((need & ~(window_rows[j] & ~window_marks[j])) != '0) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            for (int j = 0; j < PAT_H_DEFAULT; j++) begin
               window_marks[j] |= ROW_BITS'(pattern_mask[j]) << i;
            end
            match_total = saturate_count(match_total + 1);
         end
      end
   endtask

   // Advance the shadow state by one accepted row and queue the counts when
   // the row closes an image.
   task automatic predict_image_counts(input logic [ROW_BITS-1:0] pixels, input logic last);
      int                  width;
      logic [ROW_BITS-1:0] row;
      rsp_payload_type     counts;
      width = effective_width();
      row   = (width >= ROW_BITS) ? '1 : ((ROW_BITS'(1) << width) - 1);
      row  &= pixels;

      // The oldest row leaves the window: its free pixels stay unmarked for good.
      if (rows_held >= PAT_H_DEFAULT) begin
         unmarked_total = saturate_count(unmarked_total +
                                         $countones(window_rows[0] & ~window_marks[0]));
      end
      for (int j = 0; j + 1 < PAT_H_DEFAULT; j++) begin
         window_rows[j]  = window_rows[j + 1];
         window_marks[j] = window_marks[j + 1];
      end
      window_rows[PAT_H_DEFAULT - 1]  = row;
      window_marks[PAT_H_DEFAULT - 1] = '0;
      if (rows_held < MAX_ROWS_DEFAULT) begin
         rows_held++;
      end
      if (rows_held >= PAT_H_DEFAULT) begin
         scan_oldest_row();
      end

      if (last) begin
         for (int j = 0; j < PAT_H_DEFAULT; j++) begin
            unmarked_total = saturate_count(unmarked_total +
                                            $countones(window_rows[j] & ~window_marks[j]));
         end
         counts.unmarked_count = COUNT_BITS'(unmarked_total);
         counts.match_count    = COUNT_BITS'(match_total);
         expected_counts_q.push_back(counts);
         clear_image_state();
      end
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%s", msg);
      end
   endtask

   always @(posedge clock) begin : check_counts
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts_q.size() == 0) begin
            report_mismatch($sformatf("unexpected count transaction: unmarked %0d matches %0d",
                                      rsp_payload.unmarked_count, rsp_payload.match_count));
         end else begin
            want = expected_counts_q.pop_front();
            if (rsp_payload.unmarked_count !== want.unmarked_count) begin
               report_mismatch($sformatf("unmarked_count: expected %0d, got %0d",
                                         want.unmarked_count, rsp_payload.unmarked_count));
            end
            if (rsp_payload.match_count !== want.match_count) begin
               report_mismatch($sformatf("match_count: expected %0d, got %0d",
                                         want.match_count, rsp_payload.match_count));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Sends one row and returns at the edge where it is taken. Valid is left
   // high so the next row can follow without a gap; whoever stops sending
   // lowers it.
   task automatic send_row(input logic [ROW_BITS-1:0] pixels, input logic last);
      req_payload_type item;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.row_pixels = pixels;
      item.last_row   = last;
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
      predict_image_counts(pixels, last);
   endtask

   // An image of identical rows, flagged last on the final one.
   task automatic send_uniform_image(input logic [ROW_BITS-1:0] pixels, input int rows);
      for (int r = 0; r < rows; r++) begin
         send_row(pixels, r == rows - 1);
      end
   endtask

   // Stop sending and wait until every predicted count is back and the block
   // has had time to settle.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_counts_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_PATTERN_TOP:    pattern_mask[0]  = data[PAT_BITS-1:0];
         CSR_PATTERN_MID:    pattern_mask[1]  = data[PAT_BITS-1:0];
         CSR_PATTERN_BOTTOM: pattern_mask[2]  = data[PAT_BITS-1:0];
         CSR_ACTIVE_WIDTH:   active_width_cfg = data[WIDTH_BITS-1:0];
         default:            ;
      endcase
   endtask

   // All four registers go out on consecutive cycles; the enable drops after.
   task automatic apply_config(input logic [CSR_DATA_BITS-1:0] top,
                               input logic [CSR_DATA_BITS-1:0] mid,
                               input logic [CSR_DATA_BITS-1:0] bottom,
                               input logic [CSR_DATA_BITS-1:0] width_word);
      write_csr(CSR_PATTERN_TOP, top);
      write_csr(CSR_PATTERN_MID, mid);
      write_csr(CSR_PATTERN_BOTTOM, bottom);
      write_csr(CSR_ACTIVE_WIDTH, width_word);
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------

   function automatic logic [PAT_BITS-1:0] random_pattern_row();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return PAT_BITS'($urandom);
         4, 5:    return PAT_BITS'(1) << $urandom_range(0, PAT_BITS - 1);
         default: return PAT_BITS'($urandom & $urandom & $urandom);
      endcase
   endfunction

   function automatic logic [ROW_BITS-1:0] random_row(input int density);
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case (density)
         0: return a & b;
         1: return a;
         2: return a | b;
         default: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return ROW_BITS'(1) << $urandom_range(0, ROW_BITS - 1);
            endcase
         end
      endcase
   endfunction

   // Mostly widths that leave room for the pattern; now and then none, too
   // narrow, or above the row size. Half the time the unused upper data bits get noise.
   task automatic random_config();
      logic [CSR_DATA_BITS-1:0] width_word;
      case ($urandom_range(0, 19))
         0:       width_word = '0;
         1:       width_word = CSR_DATA_BITS'($urandom_range(ROW_BITS + 1, 127));
         2:       width_word = CSR_DATA_BITS'($urandom_range(1, PAT_BITS - 1));
         3:       width_word = CSR_DATA_BITS'(ROW_BITS);
         default: width_word = CSR_DATA_BITS'($urandom_range(PAT_BITS, ROW_BITS));
      endcase
      if ($urandom_range(0, 1) == 1) begin
         width_word[CSR_DATA_BITS-1:WIDTH_BITS] = (CSR_DATA_BITS - WIDTH_BITS)'($urandom);
      end
      apply_config(random_pattern_row(), random_pattern_row(), random_pattern_row(),
                   width_word);
   endtask

   // Build one image. Most images get copies of the pattern stamped in at
   // random places so that matches, and matches blocking each other, happen
   // often; the rest are plain noise.
   task automatic send_random_image(output int rows);
      logic [ROW_BITS-1:0] image [$];
      int                  density;
      int                  width;
      int                  top_row;
      int                  column;
      rows    = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      density = $urandom_range(0, 3);
      width   = effective_width();
      for (int r = 0; r < rows; r++) begin
         image.push_back(random_row(density));
      end
      if ($urandom_range(0, 3) != 0 && rows >= PAT_H_DEFAULT && width >= PAT_BITS) begin
         repeat ($urandom_range(1, 4)) begin
            top_row = $urandom_range(0, rows - PAT_H_DEFAULT);
            column  = $urandom_range(0, width - PAT_BITS);
            for (int j = 0; j < PAT_H_DEFAULT; j++) begin
               image[top_row + j] |= ROW_BITS'(pattern_mask[j]) << column;
            end
         end
      end
      for (int r = 0; r < rows; r++) begin
         send_row(image[r], r == rows - 1);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Registers at their reset values: an empty pattern matches at every
   // position and marks nothing. Also a one-row image, too short to scan.
   task automatic test_reset_defaults();
      send_row('1, 1'b0);
      send_row('0, 1'b0);
      send_row({32{2'b10}}, 1'b1);
      send_row('1, 1'b1);
      wait_until_idle();
   endtask

   // Full pattern rows, with and without an empty middle row.
   task automatic test_pattern_extremes();
      apply_config('1, '0, '1, CSR_DATA_BITS'(ROW_BITS));
      send_uniform_image('1, 3);
      send_row({16{4'b1110}}, 1'b0);
      send_row('1, 1'b0);
      send_row({16{4'b0111}}, 1'b0);
      send_row('1, 1'b1);
      wait_until_idle();
      apply_config('1, '1, '1, CSR_DATA_BITS'(ROW_BITS));
      send_uniform_image('1, 3);
      wait_until_idle();
   endtask

   // A small T-shaped pattern against the width corners: exactly one
   // position, one column short of a position, no columns at all, a width
   // above the row size, and a single column.
   task automatic test_width_corners();
      apply_config(CSR_DATA_BITS'(1), CSR_DATA_BITS'(3), CSR_DATA_BITS'(1),
                   CSR_DATA_BITS'(PAT_BITS));
      send_uniform_image('1, 3);
      wait_until_idle();
      apply_config(CSR_DATA_BITS'(1), CSR_DATA_BITS'(3), CSR_DATA_BITS'(1),
                   CSR_DATA_BITS'(PAT_BITS - 1));
      send_uniform_image('1, 3);
      wait_until_idle();
      apply_config(CSR_DATA_BITS'(1), CSR_DATA_BITS'(3), CSR_DATA_BITS'(1), '0);
      send_uniform_image('1, 2);
      wait_until_idle();
      apply_config(CSR_DATA_BITS'(1), CSR_DATA_BITS'(3), CSR_DATA_BITS'(1),
                   CSR_DATA_BITS'(127));
      send_row({$urandom, $urandom} | {$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom} | {$urandom, $urandom}, 1'b0);
      send_row({$urandom, $urandom} | {$urandom, $urandom}, 1'b1);
      wait_until_idle();
      apply_config(CSR_DATA_BITS'(1), CSR_DATA_BITS'(3), CSR_DATA_BITS'(1),
                   CSR_DATA_BITS'(1));
      send_row('1, 1'b1);
      wait_until_idle();
   endtask

   // Images far past the row limit. With an empty pattern over full rows both
   // totals overflow. With a full top row over rows that have a gap every 16
   // columns nothing can match, so only the unmarked total overflows.
   task automatic test_count_saturation();
      rsp_stall_pct = 63;
      apply_config('0, '0, '0, CSR_DATA_BITS'(ROW_BITS));
      send_uniform_image('1, 100);
      wait_until_idle();
      apply_config('1, '0, '0, CSR_DATA_BITS'(ROW_BITS));
      send_uniform_image({4{16'h7FFF}}, 70);
      wait_until_idle();
      rsp_stall_pct = 0;
   endtask

   // Phases of random images, each under a fresh register setting and its own
   // mix of sender gaps and receiver stalls.
   task automatic test_random_images();
      int rows_sent;
      int rows;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 63;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 63;
            end
            default: begin
               send_idle_pct = 22;
               rsp_stall_pct = 22;
            end
         endcase
         random_config();
         rows_sent = 0;
         while (rows_sent < PHASE_ROWS) begin
            send_random_image(rows);
            rows_sent += rows;
         end
         wait_until_idle();
      end
   endtask

   initial begin
      reset_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_pattern_extremes();
      test_width_corners();
      test_count_saturation();
      test_random_images();

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
sv/btmc_pkg.sv
sv/btmc_front.sv
sv/btmc_engine.sv
sv/binary_template_match_count_unit.sv
dv/tb_top.sv
